// ===== hdl/rmof_pkg.sv =====
`timescale 1ns / 1ps

package rmof_pkg;

   // sample word and band register widths
   localparam int SAMPLE_W = 32;
   localparam int FRAC_W   = 8;
   localparam int PROD_W   = SAMPLE_W + FRAC_W;

   // result word padded to a whole byte
   localparam int RSP_TDATA_W = 8;

   // band fraction after reset, about 0.1 in Q0.8
   localparam logic [FRAC_W-1:0] BAND_FRACTION_RESET = 8'd26;

   // extremes after a series start
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;

   // control of a word inside the window tracker
   typedef struct packed {
      logic valid;
      logic start;
      logic warming;
   } stage_ctl_type;

   // control of a word handed to the band compare
   typedef struct packed {
      logic valid;
      logic warming;
   } band_ctl_type;

   // one result word
   typedef struct packed {
      logic outlier;
      logic warming;
   } result_type;

endpackage

// ===== hdl/running_mean_outlier_flag.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake               payload
// req_      in   req_tvalid/req_tready   tdata: sample; tuser: series_start
// rsp_      out  rsp_tvalid/rsp_tready   tdata: outlier, pad; tuser: warming
// csr_      in   csr_valid/csr_ready     csr_data: band_fraction
//
// One word in and one result out per cycle while the result queue has room and
// rsp_tready is high; the delay line memory does one read and one write for each word.
// After the req accepting edge, rsp_tvalid rises once the word has passed the memory read at that
// edge, then sum and extreme update, two multiplier stages and the result queue.
// Reset clears index, count, sum and extremes; the delay line is not cleared.
// req_tready drops once 8 words are accepted and not yet delivered.

module running_mean_outlier_flag #(
   parameter int WINDOW = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rmof_pkg::SAMPLE_W-1:0]       req_tdata,   // [31:0] sample
   input  logic                                req_tuser,   // [0] series_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rmof_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [0] outlier, [7:1] zero
   output logic                                rsp_tuser,   // [0] warming
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rmof_pkg::FRAC_W-1:0]         csr_data     // band_fraction
);

   localparam int OCC_W = rmof_pkg::FIFO_AW + 1;

   logic                                 req_accept, rsp_accept;
   logic [OCC_W-1:0]                     occ_ff, occ_in;
   logic [rmof_pkg::FRAC_W-1:0]          band_fraction_ff, band_fraction_in;
   rmof_pkg::band_ctl_type               band_ctl;
   logic signed [rmof_pkg::SAMPLE_W-1:0] band_x;
   logic signed [rmof_pkg::SAMPLE_W+$clog2(WINDOW):0] band_sum;
   logic [rmof_pkg::SAMPLE_W-1:0]        band_spread;
   logic                                 res_valid;
   rmof_pkg::result_type                 res, head;

   // count words in flight so the result queue never overflows
   always_comb begin
      req_accept       = req_tvalid && req_tready;
      rsp_accept       = rsp_tvalid && rsp_tready;
      occ_in           = occ_ff + OCC_W'(req_accept) - OCC_W'(rsp_accept);
      band_fraction_in = (csr_valid && csr_ready) ? csr_data : band_fraction_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff           <= '0;
         band_fraction_ff <= rmof_pkg::BAND_FRACTION_RESET;
      end else begin
         occ_ff           <= occ_in;
         band_fraction_ff <= band_fraction_in;
      end
   end

   assign req_tready = occ_ff < OCC_W'(rmof_pkg::FIFO_DEPTH);
   assign csr_ready  = 1'b1;

   rmof_track #(
      .WINDOW (WINDOW)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .sample       ($signed(req_tdata)),
      .series_start (req_tuser),
      .band_ctl     (band_ctl),
      .band_x       (band_x),
      .band_sum     (band_sum),
      .band_spread  (band_spread)
   );

   rmof_band #(
      .WINDOW (WINDOW)
   ) u_band (
      .clock         (clock),
      .reset         (reset),
      .band_ctl      (band_ctl),
      .band_x        (band_x),
      .band_sum      (band_sum),
      .band_spread   (band_spread),
      .band_fraction (band_fraction_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   rmof_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .pop        (rsp_accept),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   // drive the result word
   assign rsp_tdata = {{(rmof_pkg::RSP_TDATA_W-1){1'b0}}, head.outlier};
   assign rsp_tuser = head.warming;

`ifndef SYNTH
   a_rsp_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ_ff != '0)
      else $error("result shown with no word in flight");

   a_no_test_when_warming: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tuser))
      else $error("outlier flagged during warm-up");
`endif

endmodule

// ===== hdl/rmof_ram.sv =====
`timescale 1ns / 1ps

module rmof_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port; a read of the entry being
   // written returns the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rmof_track.sv =====
`timescale 1ns / 1ps

module rmof_track #(
   parameter int WINDOW = 256
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_accept,
   input  logic signed [rmof_pkg::SAMPLE_W-1:0]         sample,
   input  logic                                         series_start,
   output rmof_pkg::band_ctl_type                       band_ctl,
   output logic signed [rmof_pkg::SAMPLE_W-1:0]         band_x,
   output logic signed [rmof_pkg::SAMPLE_W+$clog2(WINDOW):0] band_sum,
   output logic [rmof_pkg::SAMPLE_W-1:0]                band_spread
);

   localparam int AW    = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = rmof_pkg::SAMPLE_W + AW + 1;
   localparam int DIF_W = rmof_pkg::SAMPLE_W + 1;

   // stage 0: write index and fill count
   logic [AW-1:0]    idx_ff, idx_in, idx_base;
   logic [CNT_W-1:0] count_ff, count_in, count_base;
   logic             warm0;

   // stage 1: word waiting for the old entry
   rmof_pkg::stage_ctl_type                s1_ctl_ff, s1_ctl_in;
   logic signed [rmof_pkg::SAMPLE_W-1:0]   s1_x_ff;

   // running state
   logic signed [SUM_W-1:0]              sum_ff, sum_in, sum_base, old_ext;
   logic signed [rmof_pkg::SAMPLE_W-1:0] max_ff, max_in, max_base;
   logic signed [rmof_pkg::SAMPLE_W-1:0] min_ff, min_in, min_base;
   logic signed [DIF_W-1:0]              diff;
   logic [rmof_pkg::SAMPLE_W-1:0]        ram_rd;

   // stage 2 outputs
   rmof_pkg::band_ctl_type               s2_ctl_ff, s2_ctl_in;
   logic signed [rmof_pkg::SAMPLE_W-1:0] s2_x_ff;
   logic signed [SUM_W-1:0]              s2_sum_ff;
   logic [rmof_pkg::SAMPLE_W-1:0]        s2_spread_ff, spread_in;

   // clear index and count on a series start, then advance
   always_comb begin
      idx_base   = series_start ? '0 : idx_ff;
      count_base = series_start ? '0 : count_ff;
      warm0      = count_base < CNT_W'(WINDOW);
      idx_in     = idx_ff;
      count_in   = count_ff;
      if (req_accept) begin
         idx_in   = (idx_base == AW'(WINDOW - 1)) ? '0 : idx_base + AW'(1);
         count_in = warm0 ? count_base + CNT_W'(1) : count_base;
      end
      s1_ctl_in.valid   = req_accept;
      s1_ctl_in.start   = series_start;
      s1_ctl_in.warming = warm0;
   end

   // delay line: store the new word, fetch the oldest one at the same entry
   rmof_ram #(
      .WIDTH (rmof_pkg::SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (idx_base),
      .wr_data (sample),
      .rd_addr (idx_base),
      .rd_data (ram_rd)
   );

   // update sum and extremes in word order
   always_comb begin
      sum_base = s1_ctl_ff.start ? '0 : sum_ff;
      max_base = s1_ctl_ff.start ? rmof_pkg::SAMPLE_MIN : max_ff;
      min_base = s1_ctl_ff.start ? rmof_pkg::SAMPLE_MAX : min_ff;
      old_ext  = s1_ctl_ff.warming ? '0 : SUM_W'($signed(ram_rd));
      diff     = DIF_W'(max_base) - DIF_W'(min_base);
      spread_in = diff[DIF_W-1] ? '0 : diff[rmof_pkg::SAMPLE_W-1:0];
      sum_in   = sum_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      if (s1_ctl_ff.valid) begin
         sum_in = sum_base + SUM_W'(s1_x_ff) - old_ext;
         max_in = (s1_x_ff > max_base) ? s1_x_ff : max_base;
         min_in = (s1_x_ff < min_base) ? s1_x_ff : min_base;
      end
      s2_ctl_in.valid   = s1_ctl_ff.valid;
      s2_ctl_in.warming = s1_ctl_ff.warming;
   end

   // control and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         count_ff  <= '0;
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         sum_ff    <= '0;
         max_ff    <= rmof_pkg::SAMPLE_MIN;
         min_ff    <= rmof_pkg::SAMPLE_MAX;
      end else begin
         idx_ff    <= idx_in;
         count_ff  <= count_in;
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s2_ctl_in;
         sum_ff    <= sum_in;
         max_ff    <= max_in;
         min_ff    <= min_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_x_ff      <= sample;
      s2_x_ff      <= s1_x_ff;
      s2_sum_ff    <= sum_base;
      s2_spread_ff <= spread_in;
   end

   assign band_ctl    = s2_ctl_ff;
   assign band_x      = s2_x_ff;
   assign band_sum    = s2_sum_ff;
   assign band_spread = s2_spread_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW))
      else $error("fill count beyond window");

   a_old_only_full: assert property (@(posedge clock) disable iff (reset)
      s1_ctl_ff.valid && s1_ctl_ff.start |-> s1_ctl_ff.warming)
      else $error("series start word not warming");
`endif

endmodule

// ===== hdl/rmof_band.sv =====
`timescale 1ns / 1ps

module rmof_band #(
   parameter int WINDOW = 256
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  rmof_pkg::band_ctl_type                            band_ctl,
   input  logic signed [rmof_pkg::SAMPLE_W-1:0]              band_x,
   input  logic signed [rmof_pkg::SAMPLE_W+$clog2(WINDOW):0] band_sum,
   input  logic [rmof_pkg::SAMPLE_W-1:0]                     band_spread,
   input  logic [rmof_pkg::FRAC_W-1:0]                       band_fraction,
   output logic                                              res_valid,
   output rmof_pkg::result_type                              res
);

   localparam int CMP_W = rmof_pkg::SAMPLE_W + $clog2(WINDOW) + 11;
   localparam logic signed [CMP_W-1:0] WIN_S    = CMP_W'(WINDOW);
   localparam logic signed [CMP_W-1:0] WIN256_S = CMP_W'(WINDOW * 256);

   // stage A: scaled sample, scaled sum, spread times fraction
   rmof_pkg::band_ctl_type             a_ctl_ff;
   logic signed [CMP_W-1:0]            a_lhs_ff, a_lhs_in, a_centre_ff, a_centre_in;
   logic [rmof_pkg::PROD_W-1:0]        a_prod_ff, a_prod_in;

   // stage B: band half-width
   rmof_pkg::band_ctl_type             b_ctl_ff;
   logic signed [CMP_W-1:0]            b_lhs_ff, b_centre_ff, b_half_ff, b_half_in;
   logic signed [CMP_W-1:0]            hi, lo;

   // scale the sample and the sum to a common fixed point
   always_comb begin
      a_lhs_in    = CMP_W'(band_x) * WIN256_S;
      a_centre_in = CMP_W'(band_sum) <<< 8;
      a_prod_in   = rmof_pkg::PROD_W'(band_spread) * rmof_pkg::PROD_W'(band_fraction);
      b_half_in   = $signed(CMP_W'(a_prod_ff)) * WIN_S;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
      end else begin
         a_ctl_ff <= band_ctl;
         b_ctl_ff <= a_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_lhs_ff    <= a_lhs_in;
      a_centre_ff <= a_centre_in;
      a_prod_ff   <= a_prod_in;
      b_lhs_ff    <= a_lhs_ff;
      b_centre_ff <= a_centre_ff;
      b_half_ff   <= b_half_in;
   end

   // test against both band edges
   always_comb begin
      hi            = b_centre_ff + b_half_ff;
      lo            = b_centre_ff - b_half_ff;
      res_valid     = b_ctl_ff.valid;
      res.warming   = b_ctl_ff.warming;
      res.outlier   = !b_ctl_ff.warming && (b_lhs_ff > hi || b_lhs_ff < lo);
   end

endmodule

// ===== hdl/rmof_fifo.sv =====
`timescale 1ns / 1ps

module rmof_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rmof_pkg::result_type push_data,
   input  logic                 pop,
   output logic                 head_valid,
   output rmof_pkg::result_type head
);

   localparam int CW = rmof_pkg::FIFO_AW + 1;

   rmof_pkg::result_type          mem_ff [rmof_pkg::FIFO_DEPTH];
   logic [rmof_pkg::FIFO_AW-1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]                 count_ff, count_in;

   // advance pointers and occupancy
   always_comb begin
      wptr_in  = push ? wptr_ff + rmof_pkg::FIFO_AW'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + rmof_pkg::FIFO_AW'(1) : rptr_ff;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rptr_ff];

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != CW'(rmof_pkg::FIFO_DEPTH))
      else $error("result queue overflow");
`endif

endmodule
